FILE: sv/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Types, codes and match strings for the HTTP request stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_request;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        keep_alive;
        logic [31:0] body_length;
        logic [15:0] url_offset;
        logic [15:0] url_length;
    } out_word_t;

    localparam logic [1:0] ST_BAD  = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    localparam logic [15:0] MAX_LEN_RESET = 16'd2048;

    // lower-case match strings, first character in the low byte
    localparam logic [8*3-1:0]  K_METHOD  = "teg";
    localparam logic [8*8-1:0]  K_VERSION = "1.1/ptth";
    localparam logic [8*7-1:0]  K_PREFIX  = "//:ptth";
    localparam logic [8*11-1:0] K_CONN    = ":noitcennoc";
    localparam logic [8*10-1:0] K_KEEP    = "evila-peek";
    localparam logic [8*15-1:0] K_CLEN    = ":htgnel-tnetnoc";
    localparam logic [8*5-1:0]  K_HOST    = ":tsoh";

endpackage

FILE: sv/http_request_stream_parser.sv
// ----------------------------------------------------------------------------
// http_request_stream_parser
// Byte-wide HTTP/1.1 request line and header parser with one result per request.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle while in_ready is high. Each byte is
// parsed by a single pass of compare logic against the registered parse
// state; a finished verdict is held in an output register and a new byte is
// accepted whenever the result slot is free or being drained in the same
// cycle. Bytes after a result are dropped until new_request.
module http_request_stream_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  hrsp_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hrsp_pkg::out_word_t out_data
);

    localparam logic [3:0] PH_METHOD     = 4'd0;
    localparam logic [3:0] PH_URL_SKIP   = 4'd1;
    localparam logic [3:0] PH_URL_PREFIX = 4'd2;
    localparam logic [3:0] PH_URL_SEEK   = 4'd3;
    localparam logic [3:0] PH_URL_PATH   = 4'd4;
    localparam logic [3:0] PH_VER_SKIP   = 4'd5;
    localparam logic [3:0] PH_VER        = 4'd6;
    localparam logic [3:0] PH_HDR_NAME   = 4'd7;
    localparam logic [3:0] PH_CONN_SKIP  = 4'd8;
    localparam logic [3:0] PH_CONN_VAL   = 4'd9;
    localparam logic [3:0] PH_LEN_SKIP   = 4'd10;
    localparam logic [3:0] PH_LEN_NUM    = 4'd11;
    localparam logic [3:0] PH_HDR_IGNORE = 4'd12;
    localparam logic [3:0] PH_BODY       = 4'd13;
    localparam logic [3:0] PH_DONE       = 4'd14;

    localparam int OB = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
    localparam logic [15:0] OFS_MASK = 16'((32'd1 << OB) - 32'd1);

    logic [15:0] max_len_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  mpos_reg, mpos_next;
    logic [2:0]  cand_reg, cand_next;
    logic        cr_reg, cr_next;
    logic        empty_reg, empty_next;
    logic        ka_reg, ka_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] body_reg, body_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] pstart_reg, pstart_next;
    logic [15:0] pbytes_reg, pbytes_next;

    logic                out_valid_reg;
    hrsp_pkg::out_word_t out_reg;

    logic        accept;
    logic        fin;
    logic [1:0]  fin_st;
    logic [7:0]  c, lc;
    logic        blank;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign c     = in_data.data_byte;
    assign lc    = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    assign blank = (c == 8'h20) || (c == 8'h09);

    // per-byte parse step
    always_comb
    begin
        logic [3:0]  ph;
        logic [3:0]  m;
        logic [2:0]  cd;
        logic [35:0] v;
        logic        conn_path;
        logic        len_path;
        phase_next  = phase_reg;
        mpos_next   = mpos_reg;
        cand_next   = cand_reg;
        cr_next     = cr_reg;
        empty_next  = empty_reg;
        ka_next     = ka_reg;
        len_next    = len_reg;
        body_next   = body_reg;
        cnt_next    = cnt_reg;
        pstart_next = pstart_reg;
        pbytes_next = pbytes_reg;
        fin    = 1'b0;
        fin_st = hrsp_pkg::ST_BAD;
        m  = '0;
        cd = '0;
        v  = '0;
        conn_path = 1'b0;
        len_path  = 1'b0;
        if (in_data.new_request)
        begin
            phase_next = PH_METHOD; mpos_next = '0; cand_next = 3'b111;
            cr_next = 1'b0; empty_next = 1'b1; ka_next = 1'b0; len_next = '0;
            body_next = '0; cnt_next = '0; pstart_next = '0; pbytes_next = '0;
        end
        ph = phase_next;
        if (ph == PH_DONE)
        begin
        end
        else if (cnt_next >= max_len_reg)
        begin
            fin = 1'b1; fin_st = hrsp_pkg::ST_LONG;
        end
        else
        begin
            cnt_next = cnt_next + 16'd1;
            if (ph == PH_BODY)
            begin
                body_next = body_next + 32'd1;
                if (body_next >= len_next)
                begin
                    fin = 1'b1; fin_st = hrsp_pkg::ST_OK;
                end
            end
            else if (cr_next)
            begin
                cr_next = 1'b0;
                if (c != 8'h0A)
                    fin = 1'b1;
                else if (ph != PH_VER && empty_next)
                begin
                    if (len_next == '0)
                    begin
                        fin = 1'b1; fin_st = hrsp_pkg::ST_OK;
                    end
                    else
                    begin
                        phase_next = PH_BODY; body_next = '0;
                    end
                end
                else
                begin
                    phase_next = PH_HDR_NAME; mpos_next = '0;
                    cand_next = 3'b111; empty_next = 1'b1;
                end
            end
            else if (c == 8'h0D)
            begin
                if (ph <= PH_VER && !(ph == PH_VER && mpos_next == 4'd8))
                    fin = 1'b1;
                else
                    cr_next = 1'b1;
            end
            else if (c == 8'h0A)
                fin = 1'b1;
            else
            begin
                case (ph)
                    PH_METHOD:
                    begin
                        if (blank)
                        begin
                            if (mpos_next != 4'd3) fin = 1'b1;
                            else phase_next = PH_URL_SKIP;
                        end
                        else if (mpos_next < 4'd3 &&
                                 lc == hrsp_pkg::K_METHOD[mpos_next[1:0]*8 +: 8])
                            mpos_next = mpos_next + 4'd1;
                        else
                            fin = 1'b1;
                    end
                    PH_URL_SKIP:
                    begin
                        if (blank)
                        begin
                        end
                        else if (c == 8'h2F)
                        begin
                            pstart_next = cnt_reg & {16{!in_data.new_request}};
                            pbytes_next = 16'd1; phase_next = PH_URL_PATH;
                        end
                        else if (lc == 8'h68)
                        begin
                            mpos_next = 4'd1; phase_next = PH_URL_PREFIX;
                        end
                        else
                            fin = 1'b1;
                    end
                    PH_URL_PREFIX:
                    begin
                        if (!blank && mpos_next < 4'd7 &&
                            lc == hrsp_pkg::K_PREFIX[mpos_next[2:0]*8 +: 8])
                        begin
                            mpos_next = mpos_next + 4'd1;
                            if (mpos_next == 4'd7) phase_next = PH_URL_SEEK;
                        end
                        else
                            fin = 1'b1;
                    end
                    PH_URL_SEEK:
                    begin
                        if (blank) fin = 1'b1;
                        else if (c == 8'h2F)
                        begin
                            pstart_next = cnt_reg & {16{!in_data.new_request}};
                            pbytes_next = 16'd1; phase_next = PH_URL_PATH;
                        end
                    end
                    PH_URL_PATH:
                    begin
                        if (blank)
                        begin
                            phase_next = PH_VER_SKIP; mpos_next = '0;
                        end
                        else if (pbytes_next != 16'hFFFF)
                            pbytes_next = pbytes_next + 16'd1;
                    end
                    PH_VER_SKIP:
                    begin
                        if (blank)
                        begin
                        end
                        else if (lc != hrsp_pkg::K_VERSION[7:0])
                            fin = 1'b1;
                        else
                        begin
                            mpos_next = 4'd1; phase_next = PH_VER;
                        end
                    end
                    PH_VER:
                    begin
                        if (!blank && mpos_next < 4'd8 &&
                            lc == hrsp_pkg::K_VERSION[mpos_next[2:0]*8 +: 8])
                            mpos_next = mpos_next + 4'd1;
                        else
                            fin = 1'b1;
                    end
                    PH_HDR_NAME:
                    begin
                        empty_next = 1'b0;
                        m  = mpos_next;
                        cd = cand_next;
                        if (!(m < 4'd11 && lc == hrsp_pkg::K_CONN[m*8 +: 8])) cd[0] = 1'b0;
                        if (!(m < 4'd15 && lc == hrsp_pkg::K_CLEN[m*8 +: 8])) cd[1] = 1'b0;
                        if (!(m < 4'd5 && lc == hrsp_pkg::K_HOST[m[2:0]*8 +: 8]))
                            cd[2] = 1'b0;
                        m = m + 4'd1;
                        cand_next = cd;
                        mpos_next = m;
                        if (cd[0] && m == 4'd11) phase_next = PH_CONN_SKIP;
                        else if (cd[1] && m == 4'd15)
                        begin
                            phase_next = PH_LEN_SKIP; len_next = '0;
                        end
                        else if (cd[2] && m == 4'd5) phase_next = PH_HDR_IGNORE;
                        else if (cd == 3'b000) phase_next = PH_HDR_IGNORE;
                    end
                    PH_CONN_SKIP:
                    begin
                        if (!blank)
                        begin
                            mpos_next = '0; conn_path = 1'b1;
                        end
                    end
                    PH_CONN_VAL: conn_path = 1'b1;
                    PH_LEN_SKIP:
                    begin
                        if (!blank)
                        begin
                            phase_next = PH_LEN_NUM; len_path = 1'b1;
                        end
                    end
                    PH_LEN_NUM: len_path = 1'b1;
                    default:
                    begin
                    end
                endcase
                // keep-alive value match
                if (conn_path)
                begin
                    phase_next = PH_CONN_VAL;
                    if (mpos_next < 4'd10 && lc == hrsp_pkg::K_KEEP[mpos_next*8 +: 8])
                    begin
                        mpos_next = mpos_next + 4'd1;
                        if (mpos_next == 4'd10)
                        begin
                            ka_next = 1'b1; phase_next = PH_HDR_IGNORE;
                        end
                    end
                    else
                        phase_next = PH_HDR_IGNORE;
                end
                // saturating decimal accumulate
                if (len_path)
                begin
                    if (c >= 8'h30 && c <= 8'h39)
                    begin
                        v = ({4'd0, len_next} << 3) + ({4'd0, len_next} << 1)
                            + {32'd0, c[3:0]};
                        len_next = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
                    end
                    else
                        phase_next = PH_HDR_IGNORE;
                end
            end
        end
        if (fin)
            phase_next = PH_DONE;
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= hrsp_pkg::MAX_LEN_RESET;
            phase_reg <= PH_METHOD; mpos_reg <= '0; cand_reg <= 3'b111;
            cr_reg <= 1'b0; empty_reg <= 1'b1; ka_reg <= 1'b0; len_reg <= '0;
            body_reg <= '0; cnt_reg <= '0; pstart_reg <= '0; pbytes_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_data;
            if (accept)
            begin
                phase_reg <= phase_next; mpos_reg <= mpos_next;
                cand_reg <= cand_next; cr_reg <= cr_next; empty_reg <= empty_next;
                ka_reg <= ka_next; len_reg <= len_next; body_reg <= body_next;
                cnt_reg <= cnt_next; pstart_reg <= pstart_next;
                pbytes_reg <= pbytes_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= fin;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && fin)
        begin
            out_reg.status      <= fin_st;
            out_reg.keep_alive  <= (fin_st == hrsp_pkg::ST_OK) && ka_next;
            out_reg.body_length <= (fin_st == hrsp_pkg::ST_OK) ? len_next : '0;
            out_reg.url_offset  <= (fin_st == hrsp_pkg::ST_OK) ? pstart_next & OFS_MASK : '0;
            out_reg.url_length  <= (fin_st == hrsp_pkg::ST_OK) ? pbytes_next & OFS_MASK : '0;
        end
    end

    // checks
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != hrsp_pkg::ST_OK |->
        !out_data.keep_alive && out_data.body_length == '0)
        else $error("error result with nonzero fields");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("bad status code");
    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fin |=> phase_reg == PH_DONE)
        else $error("parser not done after result");

endmodule
